>>> hw/rtl/bfha_pkg.sv
package bfha_pkg;

	// default heap size in bytes
	localparam int unsigned HEAP_BYTES_DEF = 8192;

	// header fields
	localparam logic [15:0] SIZE_FIELD = 16'h7FFF;
	localparam logic [15:0] ALLOC_FLAG = 16'h8000;
	localparam logic [15:0] MAX_REQ    = 16'h7FFE;
	localparam logic [15:0] BEST_INIT  = 16'hFFFF;
	localparam logic [15:0] EVEN_MASK  = ~16'd1;

	// reset values of the registers
	localparam logic [13:0] LIMIT_RESET = 14'd8192;
	localparam logic        FIT_RESET   = 1'b1;

	// register indexes
	localparam logic CFG_HEAP_LIMIT = 1'b0;
	localparam logic CFG_FIT_MODE   = 1'b1;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REALLOC = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_ZERO = 2'd2,
		ST_BIG  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_A_START,
		S_A_RDH,
		S_A_LDH,
		S_A_EVAL,
		S_A_LDN,
		S_A_FOUND,
		S_A_MARK,
		S_A_END,
		S_R_RD,
		S_R_LD,
		S_R_EVAL,
		S_R_LDN,
		S_R_DECIDE,
		S_R_MARK,
		S_O_RD,
		S_O_WR,
		S_DONE
	} state_t;

endpackage

>>> hw/rtl/bfha_ram.sv
module bfha_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12,
	parameter int unsigned DW    = 16
) (
	input  logic          clk,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/best_fit_heap_allocator.sv
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  command, request_size, payload_address
// result    out        out_valid / out_stall result_address, status
// config    in         cfg_write            cfg_index, cfg_data
//
// Free reads the header, clears its allocated flag and reports; a rejected request reports
// directly. Allocate reads and scores each header, loads the next one behind a free block
// that is not last and writes each merge, then appends at the break or splits and marks
// the fitted block. Reallocate in place reads the old header, merges free blocks behind it,
// may split and marks it; a move runs the allocate walk, then reads and frees the old block.
// Reset zeroes the break, presets cfg, not the heap; a stalled result holds the sequencer.
module best_fit_heap_allocator #(
	parameter int unsigned HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [14:0] request_size,
	input  logic [12:0] payload_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] result_address,
	output logic [1:0]  status,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [13:0] cfg_data
);

	localparam int unsigned HEAP_WORDS = HEAP_BYTES / 2;
	localparam int unsigned IW = $clog2(HEAP_WORDS);
	localparam int unsigned BW = $clog2(HEAP_BYTES) + 1;
	localparam int unsigned W  = ((BW > 16) ? BW : 16) + 2;
	localparam logic [W-1:0] TWO = W'(2);
	localparam logic [W-1:0] HEAP_W = W'(HEAP_BYTES);

	bfha_pkg::state_t state_q, state_d;

	logic [BW-1:0] brk_q;
	logic [13:0]   lim_q;
	logic          fit_q;
	logic [14:0]   req_q;
	logic [12:0]   addr_q;
	logic          realloc_q;
	logic          have_q;
	logic          found_q;
	logic [W-1:0]  blk_q;
	logic [W-1:0]  best_q;
	logic [15:0]   bestsz_q;
	logic [15:0]   cur_h_q;
	logic [W-1:0]  oblk_q;
	logic [W-1:0]  bs_q;
	logic [12:0]   res_q;
	bfha_pkg::status_t st_q;
	logic          out_valid_q;
	logic [12:0]   out_addr_q;
	logic [1:0]    out_st_q;

	logic          mem_re, mem_we;
	logic [IW-1:0] mem_raddr, mem_waddr;
	logic [15:0]   mem_wdata, rdata;

	function automatic logic [IW-1:0] widx(input logic [W-1:0] b);
		return b[IW:1];
	endfunction

	bfha_ram #(.DEPTH(HEAP_WORDS), .AW(IW), .DW(16)) u_ram (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	// decode the incoming request
	logic        in_acc;
	logic [15:0] req16;
	logic        too_big;
	logic [13:0] hdr_in;
	assign in_acc  = in_valid && !in_stall;
	assign req16   = (16'(request_size) + 16'd1) & bfha_pkg::EVEN_MASK;
	assign too_big = (req16 > bfha_pkg::MAX_REQ) || ((W'(req16) + TWO) > HEAP_W);
	assign hdr_in  = 14'(14'(payload_address) - 14'd2);

	// datapath terms of the walk
	logic [W-1:0] brk_w, req_w, usable_w, lim_w;
	logic [W-1:0] cur_sz, nxt_w, nend_w, merged_w;
	logic [W-1:0] rnxt_w, rnend_w, best_sz_w;
	logic         cur_free, more, merge, take, better, found_next, eval_go;
	logic         rmore, rmerge, rfits, rsplit, asplit, grow, oom;
	logic [W-1:0] nb_w, at_w;

	assign brk_w    = W'(brk_q);
	assign req_w    = W'(req_q);
	assign lim_w    = W'(lim_q);
	assign usable_w = (lim_w > HEAP_W) ? HEAP_W : lim_w;

	assign cur_sz   = W'(cur_h_q[14:0]);
	assign cur_free = !cur_h_q[15];
	assign nxt_w    = blk_q + TWO + cur_sz;
	assign more     = nxt_w < brk_w;
	assign nend_w   = nxt_w + TWO + W'(rdata[14:0]);
	assign merge    = !rdata[15] && (nend_w <= brk_w);
	assign merged_w = nend_w - blk_q - TWO;

	assign take       = cur_free && (fit_q ? (cur_sz == req_w) : (cur_sz >= req_w));
	assign better     = cur_free && fit_q && (cur_sz > req_w) && (cur_sz < W'(bestsz_q));
	assign found_next = found_q || better;
	assign eval_go    = ((state_q == bfha_pkg::S_A_EVAL) && !(cur_free && more)) ||
	                    ((state_q == bfha_pkg::S_A_LDN) && !merge);

	assign best_sz_w = W'(bestsz_q);
	assign asplit    = best_sz_w > (req_w + TWO);
	assign grow      = have_q && cur_free;
	assign at_w      = grow ? blk_q : brk_w;
	assign nb_w      = at_w + TWO + req_w;
	assign oom       = nb_w > usable_w;

	assign rnxt_w  = oblk_q + TWO + bs_q;
	assign rmore   = rnxt_w < brk_w;
	assign rnend_w = rnxt_w + TWO + W'(rdata[14:0]);
	assign rmerge  = !rdata[15] && (rnend_w <= brk_w);
	assign rfits   = req_w <= bs_q;
	assign rsplit  = (req_w + TWO) <= bs_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfha_pkg::S_IDLE: begin
				if (in_acc) begin
					case (bfha_pkg::cmd_t'(command))
						bfha_pkg::CMD_FREE: state_d = bfha_pkg::S_O_RD;
						bfha_pkg::CMD_ALLOC, bfha_pkg::CMD_REALLOC: begin
							if (request_size == 15'd0 || too_big) begin
								state_d = bfha_pkg::S_DONE;
							end else if (command == bfha_pkg::CMD_ALLOC) begin
								state_d = bfha_pkg::S_A_START;
							end else begin
								state_d = bfha_pkg::S_R_RD;
							end
						end
						default: state_d = bfha_pkg::S_DONE;
					endcase
				end
			end
			bfha_pkg::S_A_START: state_d = (brk_q == '0) ? bfha_pkg::S_A_END : bfha_pkg::S_A_RDH;
			bfha_pkg::S_A_RDH:   state_d = bfha_pkg::S_A_LDH;
			bfha_pkg::S_A_LDH:   state_d = bfha_pkg::S_A_EVAL;
			bfha_pkg::S_A_EVAL, bfha_pkg::S_A_LDN: begin
				if (state_q == bfha_pkg::S_A_EVAL && cur_free && more) begin
					state_d = bfha_pkg::S_A_LDN;
				end else if (state_q == bfha_pkg::S_A_LDN && merge) begin
					state_d = bfha_pkg::S_A_EVAL;
				end else if (take) begin
					state_d = bfha_pkg::S_A_FOUND;
				end else if (!more) begin
					state_d = found_next ? bfha_pkg::S_A_FOUND : bfha_pkg::S_A_END;
				end else begin
					state_d = bfha_pkg::S_A_RDH;
				end
			end
			bfha_pkg::S_A_FOUND: state_d = bfha_pkg::S_A_MARK;
			bfha_pkg::S_A_MARK:  state_d = realloc_q ? bfha_pkg::S_O_RD : bfha_pkg::S_DONE;
			bfha_pkg::S_A_END: begin
				state_d = (realloc_q && !oom) ? bfha_pkg::S_O_RD : bfha_pkg::S_DONE;
			end
			bfha_pkg::S_R_RD:   state_d = bfha_pkg::S_R_LD;
			bfha_pkg::S_R_LD:   state_d = bfha_pkg::S_R_EVAL;
			bfha_pkg::S_R_EVAL: state_d = rmore ? bfha_pkg::S_R_LDN : bfha_pkg::S_R_DECIDE;
			bfha_pkg::S_R_LDN:  state_d = rmerge ? bfha_pkg::S_R_EVAL : bfha_pkg::S_R_DECIDE;
			bfha_pkg::S_R_DECIDE: state_d = rfits ? bfha_pkg::S_R_MARK : bfha_pkg::S_A_START;
			bfha_pkg::S_R_MARK: state_d = bfha_pkg::S_DONE;
			bfha_pkg::S_O_RD:   state_d = bfha_pkg::S_O_WR;
			bfha_pkg::S_O_WR:   state_d = bfha_pkg::S_DONE;
			bfha_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = bfha_pkg::S_IDLE;
				end
			end
			default: state_d = bfha_pkg::S_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = widx(blk_q);
		mem_we    = 1'b0;
		mem_waddr = widx(blk_q);
		mem_wdata = merged_w[15:0];
		case (state_q)
			bfha_pkg::S_A_RDH: mem_re = 1'b1;
			bfha_pkg::S_A_EVAL: begin
				mem_re    = cur_free && more;
				mem_raddr = widx(nxt_w);
			end
			bfha_pkg::S_A_LDN: mem_we = merge;
			bfha_pkg::S_A_FOUND: begin
				mem_we    = asplit;
				mem_waddr = widx(best_q + TWO + req_w);
				mem_wdata = 16'(best_sz_w - req_w - TWO);
			end
			bfha_pkg::S_A_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = widx(best_q);
				mem_wdata = bfha_pkg::ALLOC_FLAG | (bestsz_q & bfha_pkg::SIZE_FIELD);
			end
			bfha_pkg::S_A_END: begin
				mem_we    = !oom;
				mem_waddr = widx(at_w);
				mem_wdata = bfha_pkg::ALLOC_FLAG | {1'b0, req_q};
			end
			bfha_pkg::S_R_RD, bfha_pkg::S_O_RD: begin
				mem_re    = 1'b1;
				mem_raddr = widx(oblk_q);
			end
			bfha_pkg::S_R_EVAL: begin
				mem_re    = rmore;
				mem_raddr = widx(rnxt_w);
			end
			bfha_pkg::S_R_DECIDE: begin
				mem_we    = rfits && rsplit;
				mem_waddr = widx(oblk_q + TWO + req_w);
				mem_wdata = 16'(bs_q - req_w - TWO);
			end
			bfha_pkg::S_R_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = widx(oblk_q);
				mem_wdata = bfha_pkg::ALLOC_FLAG | {1'b0, bs_q[14:0]};
			end
			bfha_pkg::S_O_WR: begin
				mem_we    = 1'b1;
				mem_waddr = widx(oblk_q);
				mem_wdata = rdata & bfha_pkg::SIZE_FIELD;
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != bfha_pkg::S_IDLE);

	// control state, break pointer and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfha_pkg::S_IDLE;
			brk_q       <= '0;
			lim_q       <= bfha_pkg::LIMIT_RESET;
			fit_q       <= bfha_pkg::FIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				if (cfg_index == bfha_pkg::CFG_HEAP_LIMIT) begin
					lim_q <= cfg_data;
				end else begin
					fit_q <= cfg_data[0];
				end
			end
			if (state_q == bfha_pkg::S_A_END && !oom) begin
				brk_q <= BW'(nb_w);
			end
			// drop the result once taken, load the next one when done
			if (state_q == bfha_pkg::S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath of the walk
	always_ff @(posedge clk) begin
		case (state_q)
			bfha_pkg::S_IDLE: begin
				req_q     <= req16[14:0];
				addr_q    <= payload_address;
				oblk_q    <= W'(hdr_in);
				realloc_q <= (command == bfha_pkg::CMD_REALLOC);
				st_q      <= bfha_pkg::ST_OK;
				res_q     <= payload_address;
				if (command == bfha_pkg::CMD_ALLOC || command == bfha_pkg::CMD_REALLOC) begin
					res_q <= '0;
					if (request_size == 15'd0) begin
						st_q <= bfha_pkg::ST_ZERO;
					end else if (too_big) begin
						st_q <= bfha_pkg::ST_BIG;
					end
				end
			end
			bfha_pkg::S_A_START: begin
				have_q   <= (brk_q != '0);
				found_q  <= 1'b0;
				blk_q    <= '0;
				best_q   <= '0;
				bestsz_q <= bfha_pkg::BEST_INIT;
				cur_h_q  <= '0;
			end
			bfha_pkg::S_A_LDH: cur_h_q <= rdata;
			bfha_pkg::S_A_FOUND: begin
				if (asplit) begin
					bestsz_q <= {1'b0, req_q};
				end
			end
			bfha_pkg::S_A_MARK: res_q <= 13'(best_q + TWO);
			bfha_pkg::S_A_END: begin
				if (oom) begin
					st_q  <= bfha_pkg::ST_OOM;
					res_q <= '0;
				end else begin
					res_q <= 13'(at_w + TWO);
				end
			end
			bfha_pkg::S_R_LD: bs_q <= W'(rdata[14:0]);
			bfha_pkg::S_R_LDN: begin
				if (rmerge) begin
					bs_q <= rnend_w - oblk_q - TWO;
				end
			end
			bfha_pkg::S_R_DECIDE: begin
				if (rfits && rsplit) begin
					bs_q <= req_w;
				end
			end
			bfha_pkg::S_R_MARK: res_q <= addr_q;
			default: ;
		endcase
		// hold the merged header locally, then score the block
		if (state_q == bfha_pkg::S_A_LDN && merge) begin
			cur_h_q <= merged_w[15:0];
		end
		if (eval_go) begin
			if (take) begin
				best_q   <= blk_q;
				bestsz_q <= cur_h_q & bfha_pkg::SIZE_FIELD;
				found_q  <= 1'b1;
			end else begin
				if (better) begin
					best_q   <= blk_q;
					bestsz_q <= cur_h_q & bfha_pkg::SIZE_FIELD;
					found_q  <= 1'b1;
				end
				if (more) begin
					blk_q <= nxt_w;
				end
			end
		end
		if (state_q == bfha_pkg::S_DONE && (!out_valid_q || !out_stall)) begin
			out_addr_q <= res_q;
			out_st_q   <= st_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_st_q;

	// a request always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != bfha_pkg::S_IDLE))
		else $error("request accepted but sequencer stayed idle");

	// no heap write while idle
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfha_pkg::S_IDLE) |-> !mem_we)
		else $error("heap write while idle");

	// a new result is only loaded from the done state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == bfha_pkg::S_DONE))
		else $error("result raised outside done state");

	// a failed request never grants an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q != bfha_pkg::ST_OK) |-> (out_addr_q == '0))
		else $error("failed request carries an address");

	// heap read and write never hit the same cycle in any state
	a_merge_port: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> 1'b0)
		else $error("heap read and write in one cycle");

endmodule
